/* src/dmf_pkg.sv */
// Package with shared types and constants for the diploid multiplicative fitness unit.
package dmf_pkg;

  localparam int MaxLociDefault = 64;
  localparam logic [31:0] OneQ16 = 32'h0001_0000;
  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

  localparam logic [6:0] LociReset = 7'd64;
  localparam logic [15:0] DemeSizeReset = 16'd100;
  localparam logic [9:0] FirstDemesReset = 10'd1;

  typedef enum logic [1:0] {
    CFG_LOCI  = 2'd0,
    CFG_SIZE  = 2'd1,
    CFG_FIRST = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_SCORE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic [9:0]  deme_index;
    logic [63:0] alleles_first;
    logic [63:0] alleles_second;
  } score_word_t;

  typedef struct packed {
    logic [31:0] fitness;
    logic [31:0] deme_mean;
    logic [31:0] deme_max;
    logic        deme_end;
  } result_word_t;

endpackage

/* src/dmf_if.sv */
// Valid/ready channel interfaces for input, result and configuration words.
interface dmf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [5:0]  locus;
  logic        habitat;
  logic [15:0] hom_coeff;
  logic [15:0] het_coeff;
  logic [9:0]  deme_index;
  logic [63:0] alleles_first;
  logic [63:0] alleles_second;
  modport source (output valid, action, locus, habitat, hom_coeff, het_coeff, deme_index,
                  alleles_first, alleles_second, input ready);
  modport sink (input valid, action, locus, habitat, hom_coeff, het_coeff, deme_index,
                alleles_first, alleles_second, output ready);
endinterface

interface dmf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fitness;
  logic [31:0] deme_mean;
  logic [31:0] deme_max;
  logic        deme_end;
  modport source (output valid, fitness, deme_mean, deme_max, deme_end, input ready);
  modport sink (input valid, fitness, deme_mean, deme_max, deme_end, output ready);
endinterface

interface dmf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/dmf_front.sv */
// Front part: writes coefficient loads into the table and queues score words.
module dmf_front (
  input  logic                clk,
  input  logic                rst,
  dmf_in_if.sink              in_ch,
  output logic                tab_we,
  output logic [5:0]          tab_addr,
  output logic                tab_hab,
  output logic [31:0]         tab_pair,
  output logic                q_valid,
  input  logic                q_ready,
  output dmf_pkg::score_word_t q_word
);

  dmf_pkg::score_word_t slot [2];
  logic [1:0] cnt;
  logic       wptr;
  logic       rptr;
  logic       push;
  logic       pop;

  // A load word waits until every earlier score word has finished with the table.
  assign in_ch.ready = (in_ch.action == dmf_pkg::ACT_LOAD) ? ((cnt == 2'd0) && q_ready)
                                                           : (cnt != 2'd2);
  assign push = in_ch.valid && in_ch.ready && (in_ch.action == dmf_pkg::ACT_SCORE);
  assign pop = q_valid && q_ready;
  assign q_valid = cnt != 2'd0;
  assign q_word = slot[rptr];

  assign tab_we = in_ch.valid && in_ch.ready && (in_ch.action == dmf_pkg::ACT_LOAD);
  assign tab_addr = in_ch.locus;
  assign tab_hab = in_ch.habitat;
  assign tab_pair = {in_ch.het_coeff, in_ch.hom_coeff};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= '{in_ch.deme_index, in_ch.alleles_first, in_ch.alleles_second};
  end

endmodule

/* src/dmf_back.sv */
// Back part: walks the loci with one multiplier, keeps deme statistics and divides.
module dmf_back #(
  parameter int MaxLoci = dmf_pkg::MaxLociDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tab_we,
  input  logic [5:0]           tab_addr,
  input  logic                 tab_hab,
  input  logic [31:0]          tab_pair,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  dmf_pkg::score_word_t q_word,
  input  logic [6:0]           loci_in_use,
  input  logic [15:0]          deme_size,
  input  logic [9:0]           first_habitat_demes,
  dmf_out_if.source            out_ch
);

  localparam logic [6:0] MaxLociV = 7'(MaxLoci);

  logic [31:0] mem0 [64];
  logic [31:0] mem1 [64];
  logic [31:0] rd0;
  logic [31:0] rd1;

  dmf_pkg::back_state_t state, state_next;
  dmf_pkg::score_word_t cur;
  logic [6:0]  k;
  logic        hab;
  logic [31:0] w;
  logic [47:0] fsum;
  logic [31:0] fpeak;
  logic [15:0] seen;
  logic [47:0] rem;
  logic [31:0] quo;
  logic [47:0] dvs;
  logic [5:0]  dstep;
  logic        bsel1;
  logic        bsel2;
  logic [15:0] coeff;
  logic [47:0] prod;
  logic [33:0] shifted;
  logic [15:0] cnt_next;
  logic [15:0] size_eff;
  logic [48:0] trial;
  dmf_pkg::result_word_t res;
  logic        res_valid;
  logic [6:0]  n_eff;
  logic [5:0]  kidx;

  always_ff @(posedge clk) begin
    if (tab_we && !tab_hab) mem0[tab_addr] <= tab_pair;
    if (tab_we && tab_hab) mem1[tab_addr] <= tab_pair;
  end

  assign kidx = k[5:0] - 6'd1;
  always_ff @(posedge clk) begin
    rd0 <= mem0[kidx];
    rd1 <= mem1[kidx];
  end

  assign n_eff = (loci_in_use > MaxLociV) ? MaxLociV : loci_in_use;
  assign bsel1 = cur.alleles_first[kidx];
  assign bsel2 = cur.alleles_second[kidx];
  always_comb begin
    logic [31:0] e;
    e = hab ? rd1 : rd0;
    coeff = (bsel1 && bsel2) ? e[15:0] : e[31:16];
  end
  assign prod = w * coeff;
  assign shifted = prod[47:14];
  assign size_eff = (deme_size == 16'd0) ? 16'd1 : deme_size;
  assign cnt_next = seen + 16'd1;
  assign trial = {1'b0, rem} - {1'b0, dvs};

  assign q_ready = (state == dmf_pkg::ST_IDLE);
  assign out_ch.valid = res_valid;
  assign out_ch.fitness = res.fitness;
  assign out_ch.deme_mean = res.deme_mean;
  assign out_ch.deme_max = res.deme_max;
  assign out_ch.deme_end = res.deme_end;

  always_comb begin
    state_next = state;
    unique case (state)
      dmf_pkg::ST_IDLE: if (q_valid) state_next = dmf_pkg::ST_READ;
      dmf_pkg::ST_READ: state_next = (k == 7'd0) ? dmf_pkg::ST_ACC : dmf_pkg::ST_MUL;
      dmf_pkg::ST_MUL:  state_next = (k == 7'd1) ? dmf_pkg::ST_ACC : dmf_pkg::ST_READ;
      dmf_pkg::ST_ACC: begin
        if (!res_valid || out_ch.ready) begin
          state_next = (cnt_next >= size_eff || cnt_next == 16'd0) ? dmf_pkg::ST_DIV
                                                                    : dmf_pkg::ST_IDLE;
        end
      end
      dmf_pkg::ST_DIV:  if (dstep == 6'd32) state_next = dmf_pkg::ST_OUT;
      dmf_pkg::ST_OUT:  state_next = dmf_pkg::ST_IDLE;
      default:          state_next = dmf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmf_pkg::ST_IDLE;
      fsum <= '0;
      fpeak <= '0;
      seen <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == dmf_pkg::ST_ACC && state_next == dmf_pkg::ST_IDLE)
          || state == dmf_pkg::ST_OUT) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
      if (state == dmf_pkg::ST_ACC && state_next != dmf_pkg::ST_ACC) begin
        if (w > fpeak) fpeak <= w;
      end
      if (state == dmf_pkg::ST_ACC && state_next == dmf_pkg::ST_IDLE) begin
        fsum <= fsum + {16'd0, w};
        seen <= cnt_next;
      end
      if (state == dmf_pkg::ST_OUT) begin
        fsum <= '0;
        fpeak <= '0;
        seen <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dmf_pkg::ST_IDLE: begin
        cur <= q_word;
        k <= n_eff;
        hab <= (q_word.deme_index >= first_habitat_demes);
        w <= dmf_pkg::OneQ16;
      end
      dmf_pkg::ST_MUL: begin
        if (bsel1 || bsel2) w <= (shifted > {2'b0, dmf_pkg::Sat32}) ? dmf_pkg::Sat32
                                                                     : shifted[31:0];
        k <= k - 7'd1;
      end
      dmf_pkg::ST_ACC: begin
        if (!res_valid || out_ch.ready) begin
          res <= '{w, 32'd0, 32'd0, 1'b0};
          rem <= fsum + {16'd0, w};
          dvs <= (cnt_next == 16'd0) ? {17'h10000, 31'd0} : {1'b0, cnt_next, 31'd0};
          quo <= '0;
          dstep <= '0;
        end
      end
      dmf_pkg::ST_DIV: begin
        if (dstep != 6'd32) begin
          if (!trial[48]) begin
            rem <= trial[47:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            quo <= {quo[30:0], 1'b0};
          end
          dvs <= {1'b0, dvs[47:1]};
          dstep <= dstep + 6'd1;
        end
      end
      dmf_pkg::ST_OUT: begin
        res <= '{res.fitness, quo, fpeak, 1'b1};
      end
      default: ;
    endcase
  end

endmodule

/* src/diploid_multiplicative_fitness_unit.sv */
// Top level of the diploid multiplicative fitness unit.
// A score word walks the loci in use through the table read and the shared multiplier, then
// accumulates into the deme statistics; a deme-closing word then also passes the divider.
// Load words are taken once no score word is queued or in progress.
// Up to two score words queue between front and back.
// Synchronous active-high reset restores register defaults and clears the deme statistics;
// the coefficient table is not cleared.
module diploid_multiplicative_fitness_unit #(
  parameter int MaxLoci = dmf_pkg::MaxLociDefault
) (
  input logic       clk,
  input logic       rst,
  dmf_in_if.sink    in_ch,
  dmf_out_if.source out_ch,
  dmf_cfg_if.sink   cfg
);

  logic [6:0]  loci_in_use;
  logic [15:0] deme_size;
  logic [9:0]  first_habitat_demes;
  logic        tab_we;
  logic [5:0]  tab_addr;
  logic        tab_hab;
  logic [31:0] tab_pair;
  logic        q_valid;
  logic        q_ready;
  dmf_pkg::score_word_t q_word;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      loci_in_use <= dmf_pkg::LociReset;
      deme_size <= dmf_pkg::DemeSizeReset;
      first_habitat_demes <= dmf_pkg::FirstDemesReset;
    end else if (cfg.valid) begin
      case (dmf_pkg::cfg_idx_t'(cfg.index))
        dmf_pkg::CFG_LOCI:  loci_in_use <= cfg.data[6:0];
        dmf_pkg::CFG_SIZE:  deme_size <= cfg.data;
        dmf_pkg::CFG_FIRST: first_habitat_demes <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  dmf_front u_front (
    .clk, .rst, .in_ch, .tab_we, .tab_addr, .tab_hab, .tab_pair,
    .q_valid, .q_ready, .q_word
  );

  dmf_back #(.MaxLoci(MaxLoci)) u_back (
    .clk, .rst, .tab_we, .tab_addr, .tab_hab, .tab_pair, .q_valid, .q_ready, .q_word,
    .loci_in_use, .deme_size, .first_habitat_demes, .out_ch
  );

endmodule

/* src/dmf_checker.sv */
// Port-level checker for the diploid multiplicative fitness unit and its bind.
module dmf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] deme_mean,
  input logic [31:0] deme_max,
  input logic        deme_end,
  input logic [31:0] fitness
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fitness))
    else $error("result word changed while stalled");

  a_open_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !deme_end |-> deme_mean == 32'd0 && deme_max == 32'd0)
    else $error("deme statistics shown without deme end");

  a_max_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && deme_end |-> deme_max >= fitness && deme_max >= deme_mean)
    else $error("deme maximum below a member or the mean");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind diploid_multiplicative_fitness_unit dmf_checker u_dmf_checker (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .deme_mean(out_ch.deme_mean), .deme_max(out_ch.deme_max),
  .deme_end(out_ch.deme_end), .fitness(out_ch.fitness)
);

/* test/tb_diploid_multiplicative_fitness_unit.sv */
// Testbench for the diploid multiplicative fitness unit: random and directed words checked
// against a built-in fitness predictor.
module tb_diploid_multiplicative_fitness_unit;

  typedef struct {
    dmf_pkg::action_t action;
    logic [5:0]  locus;
    logic        habitat;
    logic [15:0] hom_coeff;
    logic [15:0] het_coeff;
    logic [9:0]  deme_index;
    logic [63:0] alleles_first;
    logic [63:0] alleles_second;
  } in_word_t;

  localparam int WatchLimit = 20000;

  logic clk;
  logic rst;

  dmf_in_if  in_ch ();
  dmf_out_if out_ch ();
  dmf_cfg_if cfg ();

  diploid_multiplicative_fitness_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg)
  );

  in_word_t               pending_words[$];
  dmf_pkg::result_word_t  expected_results[$];

  logic [63:0] coeff_mem[64];
  logic [47:0] sum_acc;
  logic [31:0] peak_acc;
  logic [15:0] seen_count;
  logic [6:0]  loci_reg;
  logic [15:0] size_reg;
  logic [9:0]  first_reg;

  int  error_count;
  int  idle_cycles;
  int  burst_left;
  int  gap_left;
  int  stall_phase;
  int  stall_mode;
  bit  timed_out;
  bit  in_fire;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic logic [31:0] scale_step(input logic [31:0] w, input logic [15:0] c);
    logic [47:0] prod;
    prod = ({16'd0, w} * {32'd0, c}) >> 14;
    return (prod > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  function automatic logic [31:0] individual_fitness(input in_word_t wd);
    logic [31:0] w;
    logic [63:0] e;
    int n;
    w = dmf_pkg::OneQ16;
    n = (loci_reg > 64) ? 64 : loci_reg;
    for (int k = n - 1; k >= 0; k--) begin
      e = (wd.deme_index < first_reg) ? coeff_mem[k] : (coeff_mem[k] >> 32);
      if (wd.alleles_first[k] && wd.alleles_second[k]) begin
        w = scale_step(w, e[15:0]);
      end else if (wd.alleles_first[k] || wd.alleles_second[k]) begin
        w = scale_step(w, e[31:16]);
      end
    end
    return w;
  endfunction

  task automatic predict_word(input in_word_t wd);
    dmf_pkg::result_word_t r;
    logic [15:0] lim;
    logic [16:0] div;
    if (wd.action == dmf_pkg::ACT_LOAD) begin
      if (wd.habitat) begin
        coeff_mem[wd.locus][63:32] = {wd.het_coeff, wd.hom_coeff};
      end else begin
        coeff_mem[wd.locus][31:0] = {wd.het_coeff, wd.hom_coeff};
      end
      return;
    end
    r.fitness = individual_fitness(wd);
    sum_acc = sum_acc + r.fitness;
    if (r.fitness > peak_acc) begin
      peak_acc = r.fitness;
    end
    seen_count = seen_count + 1;
    lim = (size_reg == 0) ? 16'd1 : size_reg;
    if (seen_count >= lim || seen_count == 0) begin
      div = (seen_count == 0) ? 17'h10000 : {1'b0, seen_count};
      r.deme_mean = 32'(sum_acc / div);
      r.deme_max = peak_acc;
      r.deme_end = 1'b1;
      sum_acc = '0;
      peak_acc = '0;
      seen_count = '0;
    end else begin
      r.deme_mean = '0;
      r.deme_max = '0;
      r.deme_end = 1'b0;
    end
    expected_results.push_back(r);
  endtask

  // The driver presents words in bursts separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_word_t wd;
        wd = pending_words.pop_front();
        predict_word(wd);
        in_ch.valid <= 1'b1;
        in_ch.action <= wd.action;
        in_ch.locus <= wd.locus;
        in_ch.habitat <= wd.habitat;
        in_ch.hom_coeff <= wd.hom_coeff;
        in_ch.het_coeff <= wd.het_coeff;
        in_ch.deme_index <= wd.deme_index;
        in_ch.alleles_first <= wd.alleles_first;
        in_ch.alleles_second <= wd.alleles_second;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // The receiver stalls on a pattern that changes mode now and then.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) begin
        stall_mode <= $urandom_range(0, 3);
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= (stall_phase % 8) < 3;
        default: out_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg.valid && cfg.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected word", out_ch.fitness, '0);
        end else begin
          dmf_pkg::result_word_t r;
          r = expected_results.pop_front();
          if (out_ch.fitness !== r.fitness) report("fitness", out_ch.fitness, r.fitness);
          if (out_ch.deme_mean !== r.deme_mean) report("deme_mean", out_ch.deme_mean, r.deme_mean);
          if (out_ch.deme_max !== r.deme_max) report("deme_max", out_ch.deme_max, r.deme_max);
          if (out_ch.deme_end !== r.deme_end) report("deme_end", out_ch.deme_end, r.deme_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WatchLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL diploid_multiplicative_fitness_unit");
      $finish;
    end
  end

  task automatic write_reg(input dmf_pkg::cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      dmf_pkg::CFG_LOCI: loci_reg = value[6:0];
      dmf_pkg::CFG_SIZE: size_reg = value;
      dmf_pkg::CFG_FIRST: first_reg = value[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_ch.valid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (200) @(posedge clk);
  endtask

  function automatic in_word_t load_word(input logic [5:0] loc, input logic hab,
                                         input logic [15:0] hom, input logic [15:0] het);
    in_word_t wd;
    wd = '{dmf_pkg::ACT_LOAD, loc, hab, hom, het, 10'($urandom), {$urandom, $urandom},
           {$urandom, $urandom}};
    return wd;
  endfunction

  function automatic in_word_t score_word(input logic [9:0] deme, input logic [63:0] a,
                                          input logic [63:0] b);
    in_word_t wd;
    wd = '{dmf_pkg::ACT_SCORE, 6'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
           deme, a, b};
    return wd;
  endfunction

  function automatic logic [15:0] rand_coeff();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'h4000;
      2: return 16'($urandom_range(16'h3C00, 16'h4400));
      3: return 16'($urandom_range(16'h4000, 16'hFFFF));
      4: return 16'($urandom_range(0, 16'h4000));
      default: return 16'($urandom_range(16'h3F00, 16'h4100));
    endcase
  endfunction

  function automatic logic [63:0] rand_alleles();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int phase_loci[5];
    int phase_size[5];
    int phase_first[5];
    error_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    stall_mode = 0;
    timed_out = 1'b0;
    in_fire = 1'b0;
    sum_acc = '0;
    peak_acc = '0;
    seen_count = '0;
    loci_reg = dmf_pkg::LociReset;
    size_reg = dmf_pkg::DemeSizeReset;
    first_reg = dmf_pkg::FirstDemesReset;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.locus = '0;
    in_ch.habitat = 1'b0;
    in_ch.hom_coeff = '0;
    in_ch.het_coeff = '0;
    in_ch.deme_index = '0;
    in_ch.alleles_first = '0;
    in_ch.alleles_second = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = dmf_pkg::CFG_LOCI;
    cfg.data = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Every table entry is loaded for both habitats before any scoring.
    for (int k = 0; k < 64; k++) begin
      pending_words.push_back(load_word(6'(k), 1'b0, 16'h4000, 16'h4000));
      pending_words.push_back(load_word(6'(k), 1'b1, 16'h4000, 16'h4000));
    end
    pending_words.push_back(load_word(6'd63, 1'b0, 16'hFFFF, 16'h0000));
    pending_words.push_back(load_word(6'd0, 1'b1, 16'h0000, 16'hFFFF));
    pending_words.push_back(load_word(6'd5, 1'b0, 16'h8000, 16'h2000));
    pending_words.push_back(score_word(10'd0, '1, '1));
    pending_words.push_back(score_word(10'd0, '1, '0));
    pending_words.push_back(score_word(10'd1023, '0, '1));
    pending_words.push_back(score_word(10'd1, '0, '0));
    for (int k = 0; k < 64; k++) begin
      pending_words.push_back(load_word(6'(k), 1'b0, 16'hFFFF, 16'hFFFF));
    end
    pending_words.push_back(score_word(10'd0, '1, '1));
    pending_words.push_back(load_word(6'd0, 1'b0, 16'h0000, 16'h0000));
    pending_words.push_back(score_word(10'd0, '1, '1));
    wait_drained();

    phase_loci = '{64, 1, 0, 127, 17};
    phase_size = '{1, 65535, 0, 3, 7};
    phase_first = '{0, 1023, 512, 1, 3};
    for (int p = 0; p < 5; p++) begin
      write_reg(dmf_pkg::CFG_LOCI, 16'(phase_loci[p]));
      write_reg(dmf_pkg::CFG_SIZE, 16'(phase_size[p]));
      write_reg(dmf_pkg::CFG_FIRST, 16'(phase_first[p]));
      for (int i = 0; i < 330; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          pending_words.push_back(load_word(6'($urandom), 1'($urandom), rand_coeff(),
                                            rand_coeff()));
        end else begin
          pending_words.push_back(score_word(($urandom_range(0, 3) == 0) ?
                                             10'($urandom) : 10'($urandom_range(0, 4)),
                                             rand_alleles(), rand_alleles()));
        end
      end
      // Lower the deme size mid-deme once so a long deme closes early.
      if (p == 1) begin
        wait_drained();
        write_reg(dmf_pkg::CFG_SIZE, 16'd2);
        pending_words.push_back(score_word(10'd2, rand_alleles(), rand_alleles()));
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("PASS diploid_multiplicative_fitness_unit");
    end else begin
      $display("FAIL diploid_multiplicative_fitness_unit");
    end
    $finish;
  end
endmodule
